### src/bfe_pkg.sv
// Package for the bfloat16 exponential unit: fixed-point widths, constants and
// the item type passed between pipeline sections. No dependencies.
package bfe_pkg;

  localparam int FRACTION_BITS = 32;

  localparam int SIG_W  = 8;
  localparam int L2E_FB = 55;
  localparam int L2E_W  = L2E_FB + 1;
  localparam int PROD_W = SIG_W + L2E_W;
  localparam int MAG_W  = FRACTION_BITS + 8;
  localparam int T_W    = MAG_W + 1;
  localparam int SV_W   = MAG_W + 1;
  localparam int N_W    = SV_W - FRACTION_BITS;
  localparam int Y_W    = FRACTION_BITS + 2;
  localparam int COEF_W = FRACTION_BITS + 1;
  localparam int HP_W   = Y_W + FRACTION_BITS;
  localparam int SH_W   = $clog2(Y_W + 1);
  localparam int SA_W   = 8;
  localparam int BE_W   = 10;

  localparam int SA_BASE   = 188 - FRACTION_BITS;
  localparam int SUB_BASE  = FRACTION_BITS - 133;
  localparam int EXP_BIAS  = 127;
  localparam int EXP_MAX   = 255;
  localparam int N_LO      = -136;
  localparam int N_HI      = 128;

  localparam logic [15:0] BF_INF  = 16'h7F80;
  localparam logic [15:0] BF_ONE  = 16'h3F80;
  localparam logic [15:0] BF_ZERO = 16'h0000;
  localparam logic [14:0] MAG_INF  = 15'h7F80;
  localparam logic [14:0] NEG_SAT  = 15'h42BA;
  localparam logic [14:0] POS_SAT  = 15'h42B2;
  localparam logic [14:0] NEG_TINY = 15'h3B00;
  localparam logic [14:0] POS_TINY = 15'h3B7E;

  localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;

  // Rounds num / 10^18 to the given number of fraction bits, half up.
  function automatic logic [63:0] dec_to_fixed(logic [63:0] num, int bits);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = num;
    if (r >= DEC_ONE) begin
      q = 64'd1;
      r = r - DEC_ONE;
    end
    for (int i = 0; i < bits; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= DEC_ONE) begin
        r = r - DEC_ONE;
        q = q | 64'd1;
      end
    end
    r = r << 1;
    if (r >= DEC_ONE) q = q + 64'd1;
    return q;
  endfunction

  localparam logic [L2E_W-1:0] L2E =
    L2E_W'(dec_to_fixed(64'd1442695040888963387, L2E_FB));

  localparam logic [COEF_W-1:0] COEF_F4 =
    COEF_W'(dec_to_fixed(64'd14513985302716140, FRACTION_BITS));
  localparam logic [COEF_W-1:0] COEF_F3 =
    COEF_W'(dec_to_fixed(64'd50147192376945329, FRACTION_BITS));
  localparam logic [COEF_W-1:0] COEF_F2 =
    COEF_W'(dec_to_fixed(64'd242560224581628237, FRACTION_BITS));
  localparam logic [COEF_W-1:0] COEF_F1 =
    COEF_W'(dec_to_fixed(64'd692792471813229560, FRACTION_BITS));
  localparam logic [COEF_W-1:0] COEF_F0 =
    COEF_W'(dec_to_fixed(64'd1000009597621179802, FRACTION_BITS));

  localparam int HORNER_STEPS = 4;
  localparam logic [COEF_W-1:0] HORNER_COEF [HORNER_STEPS] =
    '{COEF_F3, COEF_F2, COEF_F1, COEF_F0};

  localparam logic [HP_W-1:0] HALF_ULP = HP_W'(1) << (FRACTION_BITS - 1);

  typedef struct packed {
    logic                     spec;
    logic [15:0]              spec_res;
    logic [N_W-1:0]           n;
    logic [FRACTION_BITS-1:0] f;
    logic [Y_W-1:0]           y;
  } item_t;

endpackage

### src/bfloat16_exp_unit_top.sv
// Top level of the bfloat16 exponential unit; uses bfe_pkg, bfe_reduce,
// bfe_horner and bfe_round. A request passes through range reduction, the 4
// Horner steps and rounding in order. Throughput is one request per cycle;
// each stage holds under backpressure. Reset clears all valid bits
// asynchronously; data is not reset.
module bfloat16_exp_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_bits_o
);

  logic           valid_s [bfe_pkg::HORNER_STEPS+1];
  logic           ready_s [bfe_pkg::HORNER_STEPS+1];
  bfe_pkg::item_t item_s  [bfe_pkg::HORNER_STEPS+1];

  bfe_reduce u_reduce (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .operand_bits_i (operand_bits_i),
    .valid_o        (valid_s[0]),
    .ready_i        (ready_s[0]),
    .item_o         (item_s[0])
  );

  for (genvar g = 0; g < bfe_pkg::HORNER_STEPS; g++) begin : g_horner
    bfe_horner u_horner (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_i  (bfe_pkg::HORNER_COEF[g]),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .item_i  (item_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .item_o  (item_s[g+1])
    );
  end

  bfe_round u_round (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_s[bfe_pkg::HORNER_STEPS]),
    .ready_o       (ready_s[bfe_pkg::HORNER_STEPS]),
    .item_i        (item_s[bfe_pkg::HORNER_STEPS]),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .result_bits_o (result_bits_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("Input stalled while no result was waiting at the output.");

endmodule

### src/bfe_reduce.sv
// Front section: operand classification, scaling by log2(e) and split into
// integer n and fraction f. Three register stages. Uses bfe_pkg.
module bfe_reduce (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [15:0]    operand_bits_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bfe_pkg::item_t item_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [14:0] mag_in;
  logic        spec_d, spec1_q, spec2_q;
  logic [15:0] spec_res_d, spec_res1_q, spec_res2_q;
  logic [bfe_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [7:0]  ex_q;
  logic        neg1_q, neg2_q;

  logic [bfe_pkg::SA_W-1:0] sa;
  logic [bfe_pkg::T_W-1:0]  t_d, t_q;

  logic [bfe_pkg::T_W:0]    t_inc;
  logic [bfe_pkg::MAG_W-1:0] mag;
  logic [bfe_pkg::SV_W-1:0] sv;
  bfe_pkg::item_t item_d, item_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign item_o  = item_q;

  always_comb begin
    mag_in     = operand_bits_i[14:0];
    spec_d     = 1'b1;
    spec_res_d = operand_bits_i;
    if (mag_in > bfe_pkg::MAG_INF) begin
      spec_res_d = operand_bits_i;
    end else if (operand_bits_i[15] && mag_in >= bfe_pkg::NEG_SAT) begin
      spec_res_d = bfe_pkg::BF_ZERO;
    end else if (!operand_bits_i[15] && mag_in >= bfe_pkg::POS_SAT) begin
      spec_res_d = bfe_pkg::BF_INF;
    end else if ((operand_bits_i[15] && mag_in <= bfe_pkg::NEG_TINY) ||
                 (!operand_bits_i[15] && mag_in <= bfe_pkg::POS_TINY)) begin
      spec_res_d = bfe_pkg::BF_ONE;
    end else begin
      spec_d = 1'b0;
    end
    prod_d = bfe_pkg::PROD_W'({1'b1, operand_bits_i[6:0]}) *
             bfe_pkg::PROD_W'(bfe_pkg::L2E);
  end

  // The shift leaves one extra bit so that rounding half up is a single increment.
  always_comb begin
    sa  = bfe_pkg::SA_W'(bfe_pkg::SA_BASE - int'(ex_q));
    t_d = bfe_pkg::T_W'(prod_q >> sa);
  end

  always_comb begin
    t_inc = {1'b0, t_q} + (bfe_pkg::T_W + 1)'(1);
    mag   = t_inc[bfe_pkg::MAG_W:1];
    sv    = neg2_q ? (bfe_pkg::SV_W'(0) - {1'b0, mag}) : {1'b0, mag};
    item_d.spec     = spec2_q;
    item_d.spec_res = spec_res2_q;
    item_d.n        = sv[bfe_pkg::SV_W-1:bfe_pkg::FRACTION_BITS];
    item_d.f        = sv[bfe_pkg::FRACTION_BITS-1:0];
    item_d.y        = bfe_pkg::Y_W'(bfe_pkg::COEF_F4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      prod_q      <= prod_d;
      ex_q        <= operand_bits_i[14:7];
      neg1_q      <= operand_bits_i[15];
      spec1_q     <= spec_d;
      spec_res1_q <= spec_res_d;
    end
    if (rdy2 && v1_q) begin
      t_q         <= t_d;
      neg2_q      <= neg1_q;
      spec2_q     <= spec1_q;
      spec_res2_q <= spec_res1_q;
    end
    if (rdy3 && v2_q) begin
      item_q <= item_d;
    end
  end

  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !item_q.spec) |->
      ($signed(item_q.n) >= bfe_pkg::N_LO && $signed(item_q.n) <= bfe_pkg::N_HI))
    else $error("Range reduction produced an integer part out of range.");

endmodule

### src/bfe_horner.sv
// One Horner step y = round(y * f) + c, split into a multiply stage and a
// round-and-add stage. Uses bfe_pkg.
module bfe_horner (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bfe_pkg::COEF_W-1:0]       coef_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  bfe_pkg::item_t                   item_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output bfe_pkg::item_t                   item_o
);

  logic va_q, vb_q;
  logic rdya, rdyb;

  logic [bfe_pkg::HP_W-1:0] prod_d, prod_q, rnd;
  bfe_pkg::item_t side_q, item_d, item_q;

  assign rdyb    = !vb_q || ready_i;
  assign rdya    = !va_q || rdyb;
  assign ready_o = rdya;
  assign valid_o = vb_q;
  assign item_o  = item_q;

  always_comb begin
    prod_d = bfe_pkg::HP_W'(item_i.y) * bfe_pkg::HP_W'(item_i.f);
  end

  always_comb begin
    rnd      = prod_q + bfe_pkg::HALF_ULP;
    item_d   = side_q;
    item_d.y = bfe_pkg::Y_W'(rnd >> bfe_pkg::FRACTION_BITS) + bfe_pkg::Y_W'(coef_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdya) va_q <= valid_i;
      if (rdyb) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdya && valid_i) begin
      prod_q <= prod_d;
      side_q <= item_i;
    end
    if (rdyb && va_q) begin
      item_q <= item_d;
    end
  end

  a_y_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && !item_q.spec) |-> (item_q.y >= bfe_pkg::Y_W'(coef_i)))
    else $error("Horner step result fell below its coefficient.");

endmodule

### src/bfe_round.sv
// Final section: scale by 2^n, round to nearest even into bfloat16 (normal or
// subnormal) and merge the special cases. Three register stages. Uses bfe_pkg.
module bfe_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bfe_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [15:0]    result_bits_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic                      p_hi;
  logic [bfe_pkg::BE_W-1:0]  n_ext, be_d, sub_sh;
  logic                      normal_d, zero_d;
  logic [bfe_pkg::SH_W-1:0]  sh_d, sh_q;
  logic [bfe_pkg::Y_W-1:0]   y_q;
  logic [bfe_pkg::BE_W-1:0]  be1_q, be2_q;
  logic                      normal1_q, normal2_q, zero1_q, zero2_q;
  logic                      spec1_q, spec2_q;
  logic [15:0]               spec_res1_q, spec_res2_q;

  logic [bfe_pkg::SH_W-1:0]  shm1;
  logic [bfe_pkg::Y_W-1:0]   shifted, guard_vec, low_mask;
  logic [7:0]                q8_d, q8_q;
  logic                      rnd_up_d, rnd_up_q;

  logic [8:0]                m;
  logic [bfe_pkg::BE_W-1:0]  be_f;
  logic [6:0]                mant;
  logic [15:0]               res_d, res_q;

  assign rdy3          = !v3_q || ready_i;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign ready_o       = rdy1;
  assign valid_o       = v3_q;
  assign result_bits_o = res_q;

  // The polynomial lies in [1, 4), so the leading one is at one of two places.
  always_comb begin
    p_hi     = item_i.y[bfe_pkg::Y_W-1];
    n_ext    = bfe_pkg::BE_W'($signed(item_i.n));
    be_d     = n_ext + bfe_pkg::BE_W'(p_hi) + bfe_pkg::BE_W'(bfe_pkg::EXP_BIAS);
    sub_sh   = bfe_pkg::BE_W'(bfe_pkg::SUB_BASE) - n_ext;
    normal_d = $signed(be_d) > 0;
    zero_d   = ($signed(sub_sh) > bfe_pkg::Y_W) || ($signed(sub_sh) < 1);
    if (normal_d) begin
      sh_d = p_hi ? bfe_pkg::SH_W'(bfe_pkg::FRACTION_BITS - 6)
                  : bfe_pkg::SH_W'(bfe_pkg::FRACTION_BITS - 7);
    end else begin
      sh_d = sub_sh[bfe_pkg::SH_W-1:0];
    end
  end

  always_comb begin
    shm1      = sh_q - bfe_pkg::SH_W'(1);
    shifted   = y_q >> sh_q;
    guard_vec = y_q >> shm1;
    low_mask  = (bfe_pkg::Y_W'(1) << shm1) - bfe_pkg::Y_W'(1);
    q8_d      = shifted[7:0];
    rnd_up_d  = guard_vec[0] && ((|(y_q & low_mask)) || shifted[0]);
  end

  always_comb begin
    m    = {1'b0, q8_q} + 9'(rnd_up_q);
    be_f = be2_q + bfe_pkg::BE_W'(m[8]);
    mant = m[8] ? 7'd0 : m[6:0];
    if (spec2_q) begin
      res_d = spec_res2_q;
    end else if (normal2_q) begin
      if ($signed(be_f) >= bfe_pkg::EXP_MAX) res_d = bfe_pkg::BF_INF;
      else res_d = {1'b0, be_f[7:0], mant};
    end else if (zero2_q) begin
      res_d = bfe_pkg::BF_ZERO;
    end else begin
      res_d = 16'(m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      y_q         <= item_i.y;
      sh_q        <= sh_d;
      be1_q       <= be_d;
      normal1_q   <= normal_d;
      zero1_q     <= zero_d;
      spec1_q     <= item_i.spec;
      spec_res1_q <= item_i.spec_res;
    end
    if (rdy2 && v1_q) begin
      q8_q        <= q8_d;
      rnd_up_q    <= rnd_up_d;
      be2_q       <= be1_q;
      normal2_q   <= normal1_q;
      zero2_q     <= zero1_q;
      spec2_q     <= spec1_q;
      spec_res2_q <= spec_res1_q;
    end
    if (rdy3 && v2_q) begin
      res_q <= res_d;
    end
  end

  a_norm_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !spec2_q && normal2_q) |-> q8_q[7])
    else $error("Normal significand lost its leading one.");

endmodule

### tb/sv/bf16_exp_checker.sv
`timescale 1ns / 100ps
// Result checker for the bfloat16 exponential unit: watches the request and
// result channels, predicts e^x bit for bit and compares in order. Uses bfe_pkg.
module bf16_exp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] operand_bits_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] result_bits_i,
  input  logic        flush_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int FB = bfe_pkg::FRACTION_BITS;

  localparam logic [15:0] BF16_INF  = 16'h7F80;
  localparam logic [15:0] BF16_ONE  = 16'h3F80;
  localparam logic [15:0] BF16_ZERO = 16'h0000;
  localparam logic [14:0] NAN_ABOVE = 15'h7F80;
  localparam logic [14:0] UNDER_LIM = 15'h42BA;
  localparam logic [14:0] OVER_LIM  = 15'h42B2;
  localparam logic [14:0] NEG_NEAR1 = 15'h3B00;
  localparam logic [14:0] POS_NEAR1 = 15'h3B7E;

  localparam logic [63:0] DECIMAL_UNIT = 64'd1000000000000000000;

  typedef struct packed {
    logic [15:0] operand;
    logic [15:0] result;
  } due_t;

  due_t        exp_due[$];
  due_t        fresh;
  due_t        head;
  int          fails = 0;
  logic [63:0] log2e_fx;
  logic [63:0] poly_coef [5];

  function automatic logic [63:0] fixed_from_decimal(logic [63:0] num, int bits);
    logic [63:0] q;
    logic [63:0] r;
    q = num / DECIMAL_UNIT;
    r = num % DECIMAL_UNIT;
    for (int i = 0; i < bits; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= DECIMAL_UNIT) begin
        r = r - DECIMAL_UNIT;
        q = q | 64'd1;
      end
    end
    r = r << 1;
    if (r >= DECIMAL_UNIT) q = q + 64'd1;
    return q;
  endfunction

  initial begin
    log2e_fx     = fixed_from_decimal(64'd1442695040888963387, 55);
    poly_coef[0] = fixed_from_decimal(64'd14513985302716140, FB);
    poly_coef[1] = fixed_from_decimal(64'd50147192376945329, FB);
    poly_coef[2] = fixed_from_decimal(64'd242560224581628237, FB);
    poly_coef[3] = fixed_from_decimal(64'd692792471813229560, FB);
    poly_coef[4] = fixed_from_decimal(64'd1000009597621179802, FB);
  end

  function automatic logic [63:0] round_even_shift(logic [63:0] v, int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q    = v >> sh;
    rem  = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [15:0] bf16_exp(logic [15:0] bits);
    logic         neg;
    logic [14:0]  mag;
    logic [63:0]  sig;
    logic [63:0]  prod;
    logic [63:0]  scaled;
    logic [63:0]  fr;
    logic [63:0]  f;
    logic [63:0]  y;
    logic [63:0]  m;
    logic [127:0] wide;
    int           ex;
    int           sa;
    int           n;
    int           p;
    int           be;
    int           sh;
    neg = bits[15];
    mag = bits[14:0];
    if (mag > NAN_ABOVE) return bits;
    if (neg && mag >= UNDER_LIM) return BF16_ZERO;
    if (!neg && mag >= OVER_LIM) return BF16_INF;
    if ((neg && mag <= NEG_NEAR1) || (!neg && mag <= POS_NEAR1)) return BF16_ONE;

    ex     = int'(bits[14:7]);
    sig    = {56'd0, 1'b1, bits[6:0]};
    prod   = sig * log2e_fx;
    sa     = 189 - ex - FB;
    scaled = (prod + (64'd1 << (sa - 1))) >> sa;
    fr     = scaled & ((64'd1 << FB) - 64'd1);
    n      = int'(scaled >> FB);
    if (!neg) begin
      f = fr;
    end else begin
      n = -n - ((fr != 64'd0) ? 1 : 0);
      f = (fr != 64'd0) ? ((64'd1 << FB) - fr) : 64'd0;
    end

    y = poly_coef[0];
    for (int i = 1; i < 5; i++) begin
      wide = {64'd0, y} * {64'd0, f};
      wide = wide + (128'd1 << (FB - 1));
      y    = wide[FB +: 64] + poly_coef[i];
    end

    p = 63;
    while (p > 0 && !y[p]) p--;
    be = p - FB + n + 127;
    if (be >= 1) begin
      m = round_even_shift(y, p - 7);
      if (m >= 64'd256) begin
        m  = 64'd128;
        be = be + 1;
      end
      if (be >= 255) return BF16_INF;
      return 16'((64'(be) << 7) | (m & 64'h7F));
    end
    sh = FB - 133 - n;
    if (sh < 1 || sh > 63) return BF16_ZERO;
    return 16'(round_even_shift(y, sh));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        fresh.operand = operand_bits_i;
        fresh.result  = bf16_exp(operand_bits_i);
        exp_due.push_back(fresh);
      end
      if (out_valid_i && out_ready_i) begin
        if (exp_due.size() == 0) begin
          fails++;
          $display("%0t: result %h with no request outstanding, expected none",
                   $time, result_bits_i);
        end else begin
          head = exp_due.pop_front();
          if (result_bits_i !== head.result) begin
            fails++;
            $display("%0t: operand %h: result_bits expected %h, actual %h",
                     $time, head.operand, head.result, result_bits_i);
          end
        end
      end
      if (flush_i && exp_due.size() != 0) begin
        fails = fails + exp_due.size();
        $display("%0t: %0d results missing, expected %h next, actual none",
                 $time, exp_due.size(), exp_due[0].result);
        exp_due.delete();
      end
      fail_count_o <= fails;
      pending_o    <= exp_due.size();
    end
  end

endmodule

### tb/sv/tb_bfloat16_exp_unit_top.sv
`timescale 1ns / 100ps
// Testbench top for the bfloat16 exponential unit: drives requests and output
// stalls, and gives the verdict. Uses bfloat16_exp_unit_top and bf16_exp_checker.
module tb_bfloat16_exp_unit_top;

  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 42;
  localparam int PHASE_ITEMS    = 560;

  localparam logic [14:0] POS_CORE_LO = 15'h3B7F;
  localparam logic [14:0] POS_CORE_HI = 15'h42B1;
  localparam logic [14:0] NEG_CORE_LO = 15'h3B01;
  localparam logic [14:0] NEG_CORE_HI = 15'h42B9;
  localparam logic [14:0] NEG_DEEP_LO = 15'h42A8;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [15:0] operand   = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] result;
  logic        flush     = 1'b0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles  = 0;
  int          directed_sent = 0;
  int          random_sent   = 0;

  logic [15:0] edge_operands [25] = '{
    16'h0000, 16'h8000, 16'h0001, 16'h807F, 16'h7F80, 16'hFF80, 16'h7FC0,
    16'hFFFF, 16'h7F81, 16'h42B2, 16'h42B1, 16'hC2BA, 16'hC2B9, 16'hC2B0,
    16'hC2A0, 16'h3B7E, 16'h3B7F, 16'hBB00, 16'hBB01, 16'h3F80, 16'hBF80,
    16'h4000, 16'hC000, 16'h7F7F, 16'hFF7F
  };

  always #5 clk = ~clk;

  bfloat16_exp_unit_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operand_bits_i (operand),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_bits_o  (result)
  );

  bf16_exp_checker exp_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .operand_bits_i (operand),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_bits_i  (result),
    .flush_i        (flush),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic logic [15:0] random_operand();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return {1'b0, 15'($urandom_range(POS_CORE_HI, POS_CORE_LO))};
    if (pick < 75) return {1'b1, 15'($urandom_range(NEG_CORE_HI, NEG_CORE_LO))};
    if (pick < 85) return {1'b1, 15'($urandom_range(NEG_CORE_HI, NEG_DEEP_LO))};
    return 16'($urandom_range(16'hFFFF, 0));
  endfunction

  task automatic send_request(input logic [15:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operand  <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** bfloat16_exp_unit_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 59;
    foreach (edge_operands[i]) begin
      send_request(edge_operands[i]);
      directed_sent++;
    end
    repeat (PHASE_ITEMS) begin
      send_request(random_operand());
      random_sent++;
    end

    send_idle_pct = 59;
    recv_idle_pct = 6;
    repeat (PHASE_ITEMS) begin
      send_request(random_operand());
      random_sent++;
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (PHASE_ITEMS) begin
      send_request(random_operand());
      random_sent++;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    flush = 1'b1;
    @(negedge clk);
    flush = 1'b0;
    @(negedge clk);

    $display("Sent %0d requests: %0d edge operands (zeros, subnormals, infinities, NaNs,",
             directed_sent + random_sent, directed_sent);
    $display("  limits) and %0d random, under three idle mixes and a %0d-cycle output hold.",
             random_sent, LONG_HOLD);
    if (fail_count == 0) begin
      $display("** bfloat16_exp_unit_top: PASSED **");
    end else begin
      $display("** bfloat16_exp_unit_top: FAILED **");
    end
    $finish;
  end

endmodule
